@@ hw/rtl/mstt_pkg.sv @@
// Shared constants and controller/datapath interface types for the timer table.
`default_nettype none
package mstt_pkg;
  localparam int SLOTS      = 16;
  localparam int SLOT_BITS  = 4;
  localparam int TIME_BITS  = 32;
  localparam int COUNT_BITS = 8;
  localparam int DIV_STEPS_BITS = $clog2(TIME_BITS + 1);

  localparam logic [2:0] CMD_SET    = 3'd0;
  localparam logic [2:0] CMD_PAUSE  = 3'd1;
  localparam logic [2:0] CMD_RESUME = 3'd2;
  localparam logic [2:0] CMD_CLEAR  = 3'd3;
  localparam logic [2:0] CMD_TICK   = 3'd4;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef struct packed {
    logic accept;
    logic clr_idx;
    logic add_step;
    logic div_start;
    logic div_take;
    logic finish;
    logic inc_idx;
    logic flush;
  } ctrl_cmd_t;

  typedef struct packed {
    logic active;
    logic need_div;
    logic div_done;
    logic idx_last;
  } dp_stat_t;
endpackage
`default_nettype wire

@@ hw/rtl/mstt_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module mstt_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          go,
  input  wire logic [mstt_pkg::TIME_BITS-1:0] dividend,
  input  wire logic [mstt_pkg::TIME_BITS-1:0] divisor,
  output logic                               done,
  output logic [mstt_pkg::TIME_BITS-1:0]      quo,
  output logic [mstt_pkg::TIME_BITS-1:0]      rem
);
  logic [mstt_pkg::TIME_BITS:0]             r;
  logic [mstt_pkg::TIME_BITS-1:0]           q;
  logic [mstt_pkg::TIME_BITS-1:0]           d;
  logic [mstt_pkg::DIV_STEPS_BITS-1:0]      cnt;
  logic                                     running;
  logic [mstt_pkg::TIME_BITS:0]             shifted;
  logic                                     fits;

  assign shifted = {r[mstt_pkg::TIME_BITS-1:0], q[mstt_pkg::TIME_BITS-1]};
  assign fits    = shifted >= {1'b0, d};
  assign quo     = q;
  assign rem     = r[mstt_pkg::TIME_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        r       <= '0;
        q       <= dividend;
        d       <= divisor;
        cnt     <= mstt_pkg::DIV_STEPS_BITS'(mstt_pkg::TIME_BITS);
      end else if (running) begin
        r   <= fits ? shifted - {1'b0, d} : shifted;
        q   <= {q[mstt_pkg::TIME_BITS-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == 1) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/mstt_dp.sv @@
// Slot storage, tick arithmetic and result registers.
`default_nettype none
module mstt_dp (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire mstt_pkg::ctrl_cmd_t            cmd,
  output mstt_pkg::dp_stat_t                  stat,
  input  wire logic [2:0]                     command,
  input  wire logic [mstt_pkg::SLOT_BITS-1:0] slot,
  input  wire logic [mstt_pkg::TIME_BITS-1:0] interval,
  input  wire logic [mstt_pkg::TIME_BITS-1:0] initial_delay,
  input  wire logic                           repeat_req,
  input  wire logic [mstt_pkg::TIME_BITS-1:0] delta,
  output logic                                strobe,
  output logic                                kind,
  output logic [mstt_pkg::SLOT_BITS-1:0]      slot_out,
  output logic                                table_full,
  output logic [mstt_pkg::COUNT_BITS-1:0]     fire_count,
  output logic                                last
);
  localparam int TB = mstt_pkg::TIME_BITS;
  localparam int CB = mstt_pkg::COUNT_BITS;
  localparam int SB = mstt_pkg::SLOT_BITS;

  logic [mstt_pkg::SLOTS-1:0] valid, paused, rep, dpass;
  logic [TB-1:0] iv  [mstt_pkg::SLOTS];
  logic [TB-1:0] dl  [mstt_pkg::SLOTS];
  logic [TB-1:0] acc [mstt_pkg::SLOTS];

  logic [SB-1:0] idx;
  logic [TB-1:0] tick_delta;
  logic [TB-1:0] w_acc;
  logic [CB-1:0] w_cnt;
  logic          w_dp;
  logic          pend_v;
  logic [SB-1:0] pend_slot;
  logic [CB-1:0] pend_cnt;

  logic [SB-1:0] free_idx;
  logic          any_free;
  logic [TB:0]   sum;
  logic [TB-1:0] sat_acc;
  logic          hit_delay;
  logic          div_done;
  logic [TB-1:0] quo, rem;
  logic [TB-1:0] whole;
  logic [TB:0]   cnt_sum;
  logic [CB-1:0] cnt_new;

  always_comb begin
    free_idx = '0;
    any_free = 1'b0;
    for (int i = mstt_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_idx = SB'(i);
        any_free = 1'b1;
      end
    end
  end

  assign sum       = {1'b0, acc[idx]} + {1'b0, tick_delta};
  assign sat_acc   = sum[TB] ? {TB{1'b1}} : sum[TB-1:0];
  assign hit_delay = !dpass[idx] && (sat_acc >= dl[idx]);

  // one-shot slots count at most one whole interval
  assign whole   = (!rep[idx] && quo > 1) ? TB'(1) : quo;
  assign cnt_sum = {1'b0, whole} + {{(TB+1-CB){1'b0}}, w_cnt};
  assign cnt_new = (cnt_sum > {{(TB+1-CB){1'b0}}, mstt_pkg::COUNT_MAX}) ?
                   mstt_pkg::COUNT_MAX : cnt_sum[CB-1:0];

  mstt_div u_div (
    .clk(clk), .rst(rst), .go(cmd.div_start), .dividend(w_acc),
    .divisor(iv[idx]), .done(div_done), .quo(quo), .rem(rem)
  );

  assign stat.active   = valid[idx] && !paused[idx];
  assign stat.need_div = w_dp;
  assign stat.div_done = div_done;
  assign stat.idx_last = idx == SB'(mstt_pkg::SLOTS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      paused <= '0;
      strobe <= 1'b0;
      pend_v <= 1'b0;
      idx    <= '0;
    end else begin
      strobe <= 1'b0;
      if (cmd.accept) begin
        tick_delta <= delta;
        case (command)
          mstt_pkg::CMD_SET: begin
            strobe     <= 1'b1;
            kind       <= 1'b0;
            fire_count <= '0;
            last       <= 1'b1;
            table_full <= !any_free;
            slot_out   <= any_free ? free_idx : '0;
            if (any_free) begin
              valid[free_idx]  <= 1'b1;
              paused[free_idx] <= 1'b0;
              rep[free_idx]    <= repeat_req;
              iv[free_idx]     <= (interval == '0) ? TB'(1) : interval;
              dl[free_idx]     <= initial_delay;
              dpass[free_idx]  <= initial_delay == '0;
              acc[free_idx]    <= '0;
            end
          end
          mstt_pkg::CMD_PAUSE:  if (valid[slot]) paused[slot] <= 1'b1;
          mstt_pkg::CMD_RESUME: if (valid[slot]) paused[slot] <= 1'b0;
          mstt_pkg::CMD_CLEAR:  if (valid[slot]) valid[slot]  <= 1'b0;
          default: ;
        endcase
      end
      if (cmd.clr_idx) idx <= '0;
      if (cmd.inc_idx) idx <= idx + 1'b1;
      if (cmd.add_step) begin
        w_acc <= hit_delay ? sat_acc - dl[idx] : sat_acc;
        w_cnt <= hit_delay ? CB'(1) : '0;
        w_dp  <= dpass[idx] || hit_delay;
      end
      if (cmd.div_take) begin
        w_acc <= rem;
        w_cnt <= cnt_new;
      end
      if (cmd.finish) begin
        acc[idx]   <= w_acc;
        dpass[idx] <= w_dp;
        if (w_cnt != '0) begin
          if (!rep[idx]) valid[idx] <= 1'b0;
          // previous firing is now known not to be the final one
          if (pend_v) begin
            strobe     <= 1'b1;
            kind       <= 1'b1;
            table_full <= 1'b0;
            slot_out   <= pend_slot;
            fire_count <= pend_cnt;
            last       <= 1'b0;
          end
          pend_v    <= 1'b1;
          pend_slot <= idx;
          pend_cnt  <= w_cnt;
        end
      end
      if (cmd.flush && pend_v) begin
        strobe     <= 1'b1;
        kind       <= 1'b1;
        table_full <= 1'b0;
        slot_out   <= pend_slot;
        fire_count <= pend_cnt;
        last       <= 1'b1;
        pend_v     <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/mstt_ctrl.sv @@
// Controller: sequences a tick over all slots.
`default_nettype none
module mstt_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [2:0]         command,
  input  wire mstt_pkg::dp_stat_t stat,
  output mstt_pkg::ctrl_cmd_t     cmd,
  output logic                    busy
);
  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_ADD, S_DIVCHK, S_DIVWAIT, S_FINISH, S_NEXT, S_FLUSH
  } state_t;

  state_t state;

  assign busy = state != S_IDLE;

  always_comb begin
    cmd           = '0;
    cmd.accept    = start && state == S_IDLE;
    cmd.clr_idx   = cmd.accept && command == mstt_pkg::CMD_TICK;
    cmd.add_step  = state == S_ADD;
    cmd.div_start = state == S_DIVCHK && stat.need_div;
    cmd.div_take  = state == S_DIVWAIT && stat.div_done;
    cmd.finish    = state == S_FINISH;
    cmd.inc_idx   = state == S_NEXT && !stat.idx_last;
    cmd.flush     = state == S_FLUSH;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:    if (cmd.clr_idx) state <= S_SCAN;
        S_SCAN:    state <= stat.active ? S_ADD : S_NEXT;
        S_ADD:     state <= S_DIVCHK;
        S_DIVCHK:  state <= stat.need_div ? S_DIVWAIT : S_FINISH;
        S_DIVWAIT: if (stat.div_done) state <= S_FINISH;
        S_FINISH:  state <= S_NEXT;
        S_NEXT:    state <= stat.idx_last ? S_FLUSH : S_SCAN;
        S_FLUSH:   state <= S_IDLE;
        default:   state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/multi_slot_software_timer_table.sv @@
// Top level of the multi-slot timer table.
//  channel   signals                                           transfer when
//  command   start, busy, command, slot, interval,              start && !busy
//            initial_delay, repeat_req, delta
//  result    strobe, kind, slot_out, table_full, fire_count,    strobe
//            last
// Set, pause, resume, clear leave busy low; a set result appears next cycle.
// A tick visits every slot: an inactive slot passes scan and next, an active one
// still inside its delay passes scan, add, divchk, finish and next, and one past
// it also runs the 32-step serial divider; busy stays high through the flush step.
// Reset (synchronous) frees all slots. Results cannot be stalled.
`default_nettype none
module multi_slot_software_timer_table (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [2:0]                     command,
  input  wire logic [mstt_pkg::SLOT_BITS-1:0] slot,
  input  wire logic [mstt_pkg::TIME_BITS-1:0] interval,
  input  wire logic [mstt_pkg::TIME_BITS-1:0] initial_delay,
  input  wire logic                           repeat_req,
  input  wire logic [mstt_pkg::TIME_BITS-1:0] delta,
  output logic                                strobe,
  output logic                                kind,
  output logic [mstt_pkg::SLOT_BITS-1:0]      slot_out,
  output logic                                table_full,
  output logic [mstt_pkg::COUNT_BITS-1:0]     fire_count,
  output logic                                last
);
  mstt_pkg::ctrl_cmd_t cmd;
  mstt_pkg::dp_stat_t  stat;

  mstt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .command(command),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  mstt_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .command(command),
    .slot(slot), .interval(interval), .initial_delay(initial_delay),
    .repeat_req(repeat_req), .delta(delta), .strobe(strobe), .kind(kind),
    .slot_out(slot_out), .table_full(table_full), .fire_count(fire_count),
    .last(last)
  );
endmodule
`default_nettype wire

@@ hw/rtl/mstt_checker.sv @@
// Port-level checks for the timer table, bound to the top level.
`default_nettype none
module mstt_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           start,
  input wire logic                           busy,
  input wire logic [2:0]                     command,
  input wire logic                           strobe,
  input wire logic                           kind,
  input wire logic [mstt_pkg::SLOT_BITS-1:0] slot_out,
  input wire logic                           table_full,
  input wire logic [mstt_pkg::COUNT_BITS-1:0] fire_count,
  input wire logic                           last
);
  a_set_ack: assert property (@(posedge clk) disable iff (rst)
    start && !busy && command == mstt_pkg::CMD_SET |=> strobe && !kind && last)
    else $error("set without acknowledgement");

  a_full: assert property (@(posedge clk) disable iff (rst)
    strobe && table_full |-> !kind && slot_out == '0 && fire_count == '0)
    else $error("bad table full result");

  a_fire: assert property (@(posedge clk) disable iff (rst)
    strobe && kind |-> fire_count != '0 && !table_full)
    else $error("fire result with zero count");

  a_busy_idle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && command != mstt_pkg::CMD_TICK |=> !busy)
    else $error("non-tick command left block busy");
endmodule

bind multi_slot_software_timer_table mstt_checker u_mstt_checker (.*);
`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for the multi-slot timer table.
`default_nettype none
module tb;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 700;
  localparam int RANDOM_ITEMS   = 164;

  typedef struct packed {
    logic                            kind;
    logic [mstt_pkg::SLOT_BITS-1:0]  slot_out;
    logic                            table_full;
    logic [mstt_pkg::COUNT_BITS-1:0] fire_count;
    logic                            last;
  } timer_result_t;

  typedef struct {
    logic [2:0]                     command;
    logic [mstt_pkg::SLOT_BITS-1:0] slot;
    logic [31:0]                    interval;
    logic [31:0]                    initial_delay;
    logic                           repeat_req;
    logic [31:0]                    delta;
    bit                             typed;
    timer_result_t                  result;
  } stim_row_t;

  logic clk, rst, start, busy, repeat_req;
  logic [2:0] command;
  logic [mstt_pkg::SLOT_BITS-1:0] slot;
  logic [31:0] interval, initial_delay, delta;
  logic strobe, kind, table_full, last;
  logic [mstt_pkg::SLOT_BITS-1:0] slot_out;
  logic [mstt_pkg::COUNT_BITS-1:0] fire_count;

  multi_slot_software_timer_table dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command), .slot(slot),
    .interval(interval), .initial_delay(initial_delay), .repeat_req(repeat_req),
    .delta(delta), .strobe(strobe), .kind(kind), .slot_out(slot_out),
    .table_full(table_full), .fire_count(fire_count), .last(last)
  );

  // shadow timer table
  bit          tm_valid[mstt_pkg::SLOTS];
  bit          tm_paused[mstt_pkg::SLOTS];
  bit          tm_repeat[mstt_pkg::SLOTS];
  bit          tm_armed[mstt_pkg::SLOTS];
  logic [31:0] tm_interval[mstt_pkg::SLOTS];
  logic [31:0] tm_delay[mstt_pkg::SLOTS];
  logic [31:0] tm_acc[mstt_pkg::SLOTS];

  timer_result_t pending_results[$];
  int errors = 0;
  int transfers = 0;
  int fires_seen = 0;
  int full_seen = 0;
  int idle_cycles = 0;
  bit quiet = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic timer_result_t mk(bit k, int s, bit f, int c);
    timer_result_t r;
    r.kind = k; r.slot_out = mstt_pkg::SLOT_BITS'(s); r.table_full = f;
    r.fire_count = mstt_pkg::COUNT_BITS'(c); r.last = 1;
    return r;
  endfunction

  task automatic predict_timers(input stim_row_t it);
    timer_result_t r;
    int i, n;
    logic [32:0] sum;
    logic [31:0] acc, whole;
    int cnt;
    n = 0;
    case (it.command)
      mstt_pkg::CMD_SET: begin
        for (i = 0; i < mstt_pkg::SLOTS; i++) if (!tm_valid[i]) break;
        if (i >= mstt_pkg::SLOTS) pending_results.push_back(mk(0, 0, 1, 0));
        else begin
          tm_valid[i] = 1; tm_paused[i] = 0; tm_repeat[i] = it.repeat_req;
          tm_interval[i] = (it.interval == 0) ? 32'd1 : it.interval;
          tm_delay[i] = it.initial_delay; tm_armed[i] = (it.initial_delay == 0);
          tm_acc[i] = 0;
          pending_results.push_back(mk(0, i, 0, 0));
        end
      end
      mstt_pkg::CMD_PAUSE, mstt_pkg::CMD_RESUME, mstt_pkg::CMD_CLEAR: begin
        if (tm_valid[it.slot]) begin
          if (it.command == mstt_pkg::CMD_PAUSE) tm_paused[it.slot] = 1;
          else if (it.command == mstt_pkg::CMD_RESUME) tm_paused[it.slot] = 0;
          else tm_valid[it.slot] = 0;
        end
      end
      mstt_pkg::CMD_TICK: begin
        for (i = 0; i < mstt_pkg::SLOTS; i++) begin
          if (!tm_valid[i] || tm_paused[i]) continue;
          cnt = 0;
          sum = {1'b0, tm_acc[i]} + {1'b0, it.delta};
          acc = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          if (!tm_armed[i] && acc >= tm_delay[i]) begin
            acc -= tm_delay[i]; tm_armed[i] = 1; cnt = 1;
          end
          if (tm_armed[i]) begin
            whole = acc / tm_interval[i];
            acc = acc % tm_interval[i];
            if (!tm_repeat[i] && whole > 1) whole = 1;
            cnt = (whole >= 255 - cnt) ? 255 : cnt + whole;
          end
          tm_acc[i] = acc;
          if (cnt > 0) begin
            r = mk(1, i, 0, cnt); r.last = 0;
            pending_results.push_back(r); n++;
            if (!tm_repeat[i]) tm_valid[i] = 0;
          end
        end
        if (n > 0) pending_results[$].last = 1;
      end
      default: ;
    endcase
  endtask

  // result checker
  always @(posedge clk) begin
    timer_result_t got, want;
    if (!rst && strobe) begin
      got = '{kind, slot_out, table_full, fire_count, last};
      transfers++;
      if (kind) fires_seen++;
      if (table_full) full_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %p", $time, got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: expected %p, actual %p", $time, want, got);
        end
      end
    end
  end

  // watchdog on idle cycles
  always @(posedge clk) begin
    if (rst || strobe || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // start stays high between back-to-back items; it drops only for an idle gap
  task automatic send_item(input stim_row_t it);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    command <= it.command; slot <= it.slot; interval <= it.interval;
    initial_delay <= it.initial_delay; repeat_req <= it.repeat_req; delta <= it.delta;
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (it.typed) pending_results.push_back(it.result);
    else predict_timers(it);
    // keep shadow state in step for typed set rows too
    if (it.typed && it.command == mstt_pkg::CMD_SET) begin
      void'(pending_results.pop_back());
      predict_timers(it);
      if (pending_results[$] !== it.result) begin
        errors++;
        $display("%0t: expected %p, actual %p (typed row)", $time, it.result,
                 pending_results[$]);
      end
    end
  endtask

  function automatic stim_row_t row(int c, int s, logic [31:0] iv, logic [31:0] dl,
                                    bit rp, logic [31:0] d);
    stim_row_t r;
    r.command = 3'(c); r.slot = mstt_pkg::SLOT_BITS'(s); r.interval = iv;
    r.initial_delay = dl; r.repeat_req = rp; r.delta = d; r.typed = 0; r.result = '0;
    return r;
  endfunction

  function automatic stim_row_t typed_row(stim_row_t r, timer_result_t res);
    r.typed = 1; r.result = res;
    return r;
  endfunction

  function automatic logic [31:0] rand_time();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(1, 8);
      3: return $urandom_range(1, 200);
      4: return $urandom_range(1, 5000);
      default: return $urandom();
    endcase
  endfunction

  task automatic run_random(input int count);
    stim_row_t it;
    int k, c;
    for (k = 0; k < count; k++) begin
      if (k > count - 30) quiet = 1;
      c = $urandom_range(0, 9);
      if (c < 4) c = mstt_pkg::CMD_SET;
      else if (c < 7) c = mstt_pkg::CMD_TICK;
      else if (c == 9 && $urandom_range(0, 3) == 0) c = $urandom_range(5, 7);
      else c = $urandom_range(mstt_pkg::CMD_PAUSE, mstt_pkg::CMD_CLEAR);
      it = row(c, $urandom_range(0, 15), rand_time(), rand_time(), $urandom_range(0, 1),
               rand_time());
      if ($urandom_range(0, 7) == 0) it.slot = mstt_pkg::SLOT_BITS'($urandom());
      send_item(it);
    end
  endtask

  initial begin
    stim_row_t rows[$];
    int i;
    rst = 1; start = 0; command = mstt_pkg::CMD_SET; slot = 0; interval = 0;
    initial_delay = 0; repeat_req = 0; delta = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    rows.push_back(typed_row(row(mstt_pkg::CMD_SET, 0, 0, 0, 1, 0), mk(0, 0, 0, 0)));
    rows.push_back(typed_row(row(mstt_pkg::CMD_SET, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                 0, 0), mk(0, 1, 0, 0)));
    rows.push_back(row(mstt_pkg::CMD_SET, 0, 10, 5, 0, 0));
    rows.push_back(row(mstt_pkg::CMD_TICK, 0, 0, 0, 0, 3));
    rows.push_back(row(mstt_pkg::CMD_PAUSE, 2, 0, 0, 0, 0));
    rows.push_back(row(mstt_pkg::CMD_TICK, 0, 0, 0, 0, 100));
    rows.push_back(row(mstt_pkg::CMD_RESUME, 2, 0, 0, 0, 0));
    rows.push_back(row(mstt_pkg::CMD_TICK, 0, 0, 0, 0, 40));
    rows.push_back(row(mstt_pkg::CMD_CLEAR, 1, 0, 0, 0, 0));
    rows.push_back(row(mstt_pkg::CMD_PAUSE, 9, 0, 0, 0, 0));
    rows.push_back(row(5, 0, 0, 0, 0, 0));
    rows.push_back(row(7, 15, 0, 0, 0, 0));
    for (i = 0; i < 15; i++) rows.push_back(row(mstt_pkg::CMD_SET, 0, 7, 3, 1, 0));
    rows.push_back(typed_row(row(mstt_pkg::CMD_SET, 0, 1, 1, 1, 0), mk(0, 0, 1, 0)));
    rows.push_back(row(mstt_pkg::CMD_TICK, 0, 0, 0, 0, 32'hFFFF_FFFF));
    rows.push_back(row(mstt_pkg::CMD_TICK, 0, 0, 0, 0, 32'hFFFF_FFFF));
    foreach (rows[j]) send_item(rows[j]);
    for (i = 0; i < mstt_pkg::SLOTS; i++) send_item(row(mstt_pkg::CMD_CLEAR, i, 0, 0, 0, 0));

    run_random(RANDOM_ITEMS);
    start <= 0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run: %0d results checked, %0d fire results, %0d table-full replies.",
             transfers, fires_seen, full_seen);
    if (errors == 0 && pending_results.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
